[hdl/sst_pkg.sv]
// shared types, token kinds and character tables for the source tokenizer
package sst_pkg;

  localparam int START_W = 24;
  localparam int LINE_W = 20;
  localparam logic [START_W-1:0] START_MAX = {START_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_OUT_MAX = {LINE_W{1'b1}};

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W = 3;
  localparam int CNT_W = 4;

  localparam logic [5:0] K_DOT = 6'd7;
  localparam logic [5:0] K_SLASH = 6'd12;
  localparam logic [5:0] K_BANG = 6'd15;
  localparam logic [5:0] K_EQ = 6'd17;
  localparam logic [5:0] K_LESS = 6'd19;
  localparam logic [5:0] K_GREATER = 6'd21;
  localparam logic [5:0] K_STRING = 6'd23;
  localparam logic [5:0] K_NUMBER = 6'd24;
  localparam logic [5:0] K_IDENT = 6'd25;
  localparam logic [5:0] K_KW0 = 6'd26;
  localparam logic [5:0] K_EOF = 6'd45;
  localparam logic [5:0] K_ERROR = 6'd46;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_UNEXPECTED = 2'd1;
  localparam logic [1:0] E_UNTERMINATED = 2'd2;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ = 8'h3D;

  localparam int KW_COUNT = 19;
  // first character in the highest used byte, right justified
  localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
    "and", "begin", "end", "meta", "self", "global", "else", "false", "for",
    "fn", "if", "nil", "or", "return", "true", "while", "from", "load", "as"
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_STR,
    ST_NUM,
    ST_NUMDOT,
    ST_FRAC,
    ST_IDENT
  } mode_t;

  typedef struct packed {
    logic              last;
    logic [1:0]        err;
    logic [LINE_W-1:0] line;
    logic [START_W-1:0] len;
    logic [START_W-1:0] start;
    logic [5:0]        kind;
  } result_t;

  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     item;
  } push_t;

  function automatic logic [5:0] word_kind(input logic [55:0] w);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (w == KW_TEXT[i]) k = 6'(K_KW0 + 6'(i));
    end
    return k;
  endfunction

  // valid bit on top, kind below
  function automatic logic [6:0] single_kind(input logic [7:0] c);
    logic [6:0] r;
    case (c)
      "(": r = {1'b1, 6'd0};
      ")": r = {1'b1, 6'd1};
      "[": r = {1'b1, 6'd2};
      "]": r = {1'b1, 6'd3};
      "{": r = {1'b1, 6'd4};
      "}": r = {1'b1, 6'd5};
      ",": r = {1'b1, 6'd6};
      ".": r = {1'b1, K_DOT};
      "-": r = {1'b1, 6'd8};
      "+": r = {1'b1, 6'd9};
      ";": r = {1'b1, 6'd10};
      "*": r = {1'b1, 6'd11};
      "%": r = {1'b1, 6'd14};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] op_kind(input logic [7:0] c);
    logic [6:0] r;
    case (c)
      "/": r = {1'b1, K_SLASH};
      "!": r = {1'b1, K_BANG};
      "=": r = {1'b1, K_EQ};
      "<": r = {1'b1, K_LESS};
      ">": r = {1'b1, K_GREATER};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/script_source_tokenizer.sv]
// top level of the source tokenizer: input register, scanner and result queue
// path: a byte goes from the input register through the scanner into the result queue
// throughput: one byte per cycle while results average at most one per byte; up to three
// results of one byte are absorbed by the eight-entry result queue, which stalls input when
// fewer than three entries are free
// reset: rst clears the scanner to idle at offset 0, line 1, and empties the queue
module script_source_tokenizer #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_byte
  input  logic        s_tuser,   // is_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // token_start, token_length, line_number, zero pad
  output logic [7:0]  m_tuser,   // token_kind, error_code
  output logic        m_tlast    // run_last
);

  logic in_valid;
  logic [7:0] in_byte;
  logic in_end;
  logic room;
  logic fire;
  sst_pkg::push_t push;
  sst_pkg::result_t out;

  assign fire = in_valid && room;
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_end <= s_tuser;
    end
  end

  sst_scan #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS(LINE_BITS)
  ) u_scan (
    .clk(clk),
    .rst(rst),
    .fire(fire),
    .in_byte(in_byte),
    .in_end(in_end),
    .push(push)
  );

  sst_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .room(room),
    .out(out),
    .out_valid(m_tvalid),
    .out_ready(m_tready)
  );

  assign m_tdata = {4'b0, out.line, out.len, out.start};
  assign m_tuser = {out.err, out.kind};
  assign m_tlast = out.last;

endmodule

[hdl/sst_scan.sv]
// scanner state machine and token result generation for one source byte
module sst_scan #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         in_byte,
  input  logic               in_end,
  output sst_pkg::push_t     push
);

  localparam int EXT_W = OFFSET_BITS + sst_pkg::START_W;
  localparam int LEXT_W = LINE_BITS + sst_pkg::LINE_W;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  sst_pkg::mode_t mode, mode_next;
  logic [5:0] pend, pend_next;
  logic [OFFSET_BITS-1:0] tbeg, tbeg_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic [55:0] word, word_next;
  logic [2:0] wlen, wlen_next;
  logic halted, halted_next;

  sst_pkg::result_t [2:0] res;
  sst_pkg::result_t [1:0] fl;
  logic [1:0] fl_n;
  logic [1:0] n;
  logic again;
  logic [OFFSET_BITS-1:0] dot;
  logic [OFFSET_BITS-1:0] tb_str;
  logic [LINE_BITS-1:0] line_inc;
  logic [sst_pkg::LINE_W-1:0] line_o;
  logic [LEXT_W-1:0] line_ext;
  logic [6:0] sk;
  logic [6:0] ok;
  logic is_digit, is_alpha;

  function automatic logic [OFFSET_BITS-1:0] span(input logic [OFFSET_BITS-1:0] a,
                                                  input logic [OFFSET_BITS-1:0] b);
    return (b >= a) ? b - a : '0;
  endfunction

  function automatic sst_pkg::result_t mk(input logic [5:0] kind,
                                          input logic [OFFSET_BITS-1:0] start,
                                          input logic [OFFSET_BITS-1:0] len,
                                          input logic [1:0] err);
    sst_pkg::result_t r;
    logic [EXT_W-1:0] s_ext;
    logic [EXT_W-1:0] l_ext;
    s_ext = EXT_W'(start);
    l_ext = EXT_W'(len);
    r = '0;
    r.kind = kind;
    r.start = s_ext[sst_pkg::START_W-1:0];
    r.len = (l_ext > EXT_W'(sst_pkg::START_MAX)) ? sst_pkg::START_MAX
                                                 : l_ext[sst_pkg::START_W-1:0];
    r.err = err;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sst_pkg::ST_IDLE;
      pend <= '0;
      tbeg <= '0;
      pos <= '0;
      line <= LINE_BITS'(1);
      word <= '0;
      wlen <= '0;
      halted <= 1'b0;
    end else if (fire) begin
      mode <= mode_next;
      pend <= pend_next;
      tbeg <= tbeg_next;
      pos <= pos_next;
      line <= line_next;
      word <= word_next;
      wlen <= wlen_next;
      halted <= halted_next;
    end
  end

  always_comb begin
    dot = (pos != '0) ? pos - OFFSET_BITS'(1) : '0;
    tb_str = (pos == POS_MAX) ? pos : pos + OFFSET_BITS'(1);
    line_inc = (line == LINE_MAX) ? line : line + LINE_BITS'(1);
    line_ext = LEXT_W'(line);
    line_o = (line_ext > LEXT_W'(sst_pkg::LINE_OUT_MAX)) ? sst_pkg::LINE_OUT_MAX
                                                        : line_ext[sst_pkg::LINE_W-1:0];
    sk = sst_pkg::single_kind(in_byte);
    ok = sst_pkg::op_kind(in_byte);
    is_digit = in_byte inside {["0":"9"]};
    is_alpha = in_byte inside {["a":"z"], ["A":"Z"]};

    // token held open by the current mode
    fl = '0;
    fl_n = 2'd0;
    case (mode)
      sst_pkg::ST_OP: begin
        fl[0] = mk(pend, tbeg, OFFSET_BITS'(1), sst_pkg::E_NONE);
        fl_n = 2'd1;
      end
      sst_pkg::ST_NUM, sst_pkg::ST_FRAC: begin
        fl[0] = mk(sst_pkg::K_NUMBER, tbeg, span(tbeg, pos), sst_pkg::E_NONE);
        fl_n = 2'd1;
      end
      sst_pkg::ST_NUMDOT: begin
        fl[0] = mk(sst_pkg::K_NUMBER, tbeg, span(tbeg, dot), sst_pkg::E_NONE);
        fl[1] = mk(sst_pkg::K_DOT, dot, OFFSET_BITS'(1), sst_pkg::E_NONE);
        fl_n = 2'd2;
      end
      sst_pkg::ST_IDENT: begin
        fl[0] = mk(sst_pkg::word_kind(word), tbeg, span(tbeg, pos), sst_pkg::E_NONE);
        fl_n = 2'd1;
      end
      default: begin
        fl_n = 2'd0;
      end
    endcase

    mode_next = mode;
    pend_next = pend;
    tbeg_next = tbeg;
    pos_next = pos;
    line_next = line;
    word_next = word;
    wlen_next = wlen;
    halted_next = halted;
    res = '0;
    n = 2'd0;
    again = 1'b0;

    if (in_end) begin
      if (!halted) begin
        if (mode == sst_pkg::ST_STR) begin
          res[n] = mk(sst_pkg::K_ERROR, tbeg, span(tbeg, pos), sst_pkg::E_UNTERMINATED);
          n = n + 2'd1;
        end else begin
          for (int j = 0; j < 2; j++) begin
            if (2'(j) < fl_n) begin
              res[n] = fl[j];
              n = n + 2'd1;
            end
          end
        end
      end
      res[n] = mk(sst_pkg::K_EOF, pos, '0, sst_pkg::E_NONE);
      n = n + 2'd1;
      mode_next = sst_pkg::ST_IDLE;
      pend_next = '0;
      tbeg_next = '0;
      pos_next = '0;
      line_next = LINE_BITS'(1);
      word_next = '0;
      wlen_next = '0;
      halted_next = 1'b0;
    end else if (!halted) begin
      case (mode)
        sst_pkg::ST_OP: begin
          if ((pend == sst_pkg::K_SLASH && in_byte == sst_pkg::CH_SLASH) ||
              (pend != sst_pkg::K_SLASH && in_byte == sst_pkg::CH_EQ)) begin
            res[n] = mk(pend + 6'd1, tbeg, OFFSET_BITS'(2), sst_pkg::E_NONE);
            n = n + 2'd1;
            mode_next = sst_pkg::ST_IDLE;
            pend_next = '0;
          end else begin
            again = 1'b1;
          end
        end
        sst_pkg::ST_STR: begin
          if (in_byte == sst_pkg::CH_QUOTE) begin
            res[n] = mk(sst_pkg::K_STRING, tbeg, span(tbeg, pos), sst_pkg::E_NONE);
            n = n + 2'd1;
            mode_next = sst_pkg::ST_IDLE;
          end else if (in_byte == sst_pkg::CH_NL) begin
            line_next = line_inc;
          end
        end
        sst_pkg::ST_NUM: begin
          if (in_byte == sst_pkg::CH_DOT) mode_next = sst_pkg::ST_NUMDOT;
          else if (!is_digit && !is_alpha) again = 1'b1;
        end
        sst_pkg::ST_NUMDOT: begin
          if (is_digit) mode_next = sst_pkg::ST_FRAC;
          else again = 1'b1;
        end
        sst_pkg::ST_FRAC: begin
          if (!is_digit) again = 1'b1;
        end
        sst_pkg::ST_IDENT: begin
          if (is_digit || is_alpha || in_byte == sst_pkg::CH_UNDER) begin
            if (wlen != 3'd7) begin
              word_next = {word[47:0], in_byte};
              wlen_next = wlen + 3'd1;
            end
          end else begin
            again = 1'b1;
          end
        end
        default: begin
          again = 1'b1;
        end
      endcase

      if (again) begin
        for (int j = 0; j < 2; j++) begin
          if (2'(j) < fl_n) begin
            res[n] = fl[j];
            n = n + 2'd1;
          end
        end
        mode_next = sst_pkg::ST_IDLE;
        pend_next = '0;
        if (sk[6]) begin
          res[n] = mk(sk[5:0], pos, OFFSET_BITS'(1), sst_pkg::E_NONE);
          n = n + 2'd1;
        end else if (ok[6]) begin
          mode_next = sst_pkg::ST_OP;
          pend_next = ok[5:0];
          tbeg_next = pos;
        end else if (in_byte inside {" ", 8'h0D, 8'h09}) begin
          mode_next = sst_pkg::ST_IDLE;
        end else if (in_byte == sst_pkg::CH_NL) begin
          line_next = line_inc;
        end else if (in_byte == sst_pkg::CH_QUOTE) begin
          mode_next = sst_pkg::ST_STR;
          tbeg_next = tb_str;
        end else if (is_digit) begin
          mode_next = sst_pkg::ST_NUM;
          tbeg_next = pos;
        end else if (is_alpha || in_byte == sst_pkg::CH_UNDER) begin
          mode_next = sst_pkg::ST_IDENT;
          tbeg_next = pos;
          word_next = 56'(in_byte);
          wlen_next = 3'd1;
        end else begin
          res[n] = mk(sst_pkg::K_ERROR, pos, OFFSET_BITS'(1), sst_pkg::E_UNEXPECTED);
          n = n + 2'd1;
          halted_next = 1'b1;
        end
      end

      pos_next = (pos == POS_MAX) ? pos : pos + OFFSET_BITS'(1);
    end

    for (int i = 0; i < 3; i++) begin
      res[i].line = line_o;
      res[i].last = (2'(i) == n - 2'd1);
    end
    push.count = fire ? n : 2'd0;
    push.item = res;
  end

  a_end_emits: assert property (@(posedge clk) disable iff (rst)
    fire && in_end |-> push.count != 2'd0)
    else $error("end of source produced no result");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    fire && halted && !in_end |-> push.count == 2'd0)
    else $error("result produced after an error");

  a_end_rearms: assert property (@(posedge clk) disable iff (rst)
    fire && in_end |=> mode == sst_pkg::ST_IDLE && !halted && pos == '0)
    else $error("scanner not re-armed after end of source");

endmodule

[hdl/sst_fifo.sv]
// result queue taking up to three results a cycle and giving one word a cycle while out_ready is high
module sst_fifo (
  input  logic              clk,
  input  logic              rst,
  input  sst_pkg::push_t    push,
  output logic              room,
  output sst_pkg::result_t  out,
  output logic              out_valid,
  input  logic              out_ready
);

  sst_pkg::result_t q [sst_pkg::FIFO_DEPTH];
  logic [sst_pkg::PTR_W-1:0] wr, rd;
  logic [sst_pkg::CNT_W-1:0] count, count_next;
  logic pop;

  assign out_valid = count != '0;
  assign pop = out_valid && out_ready;
  assign out = q[rd];
  assign room = count <= sst_pkg::CNT_W'(sst_pkg::FIFO_DEPTH - 3);
  assign count_next = count + sst_pkg::CNT_W'(push.count) - sst_pkg::CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      count <= '0;
    end else begin
      wr <= wr + sst_pkg::PTR_W'(push.count);
      if (pop) rd <= rd + sst_pkg::PTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push.count) q[wr + sst_pkg::PTR_W'(i)] <= push.item[i];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sst_pkg::CNT_W'(sst_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == sst_pkg::CNT_W'($past(count) +
      sst_pkg::CNT_W'($past(push.count)) - sst_pkg::CNT_W'($past(pop))))
    else $error("result queue count out of step");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("push without room");

endmodule
